@@ hdl/srfp_pkg.sv @@
// Shared types and constants for the sonar return frame parser.
`default_nettype none

package srfp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h49;  // 'I'
  localparam logic [7:0] MARK_BYTE = 8'h58;  // 'X'
  localparam logic [7:0] TERM_BYTE = 8'hFC;
  localparam logic [7:0] TYPE_M_BYTE = 8'h4D;
  localparam logic [7:0] TYPE_G_BYTE = 8'h47;
  localparam logic [7:0] TYPE_P_BYTE = 8'h50;

  localparam int unsigned HDR_LEN = 9;
  localparam logic [3:0] HDR_LAST = 4'(HDR_LEN - 1);
  localparam logic [8:0] M_LAST_IDX = 9'd251;
  localparam logic [8:0] G_LAST_IDX = 9'd499;

  localparam logic [7:0] RANGE_RESET = 8'd5;

  localparam logic RES_SAMPLE = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_MARK    = 3'd2,
    PH_HEADER  = 3'd3,
    PH_SAMPLES = 3'd4,
    PH_TERM    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_M       = 2'd0,
    KIND_G       = 2'd1,
    KIND_P       = 2'd2,
    KIND_UNKNOWN = 2'd3
  } pkt_kind_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  echo_sample;
    logic [8:0]  sample_index;
    logic        last_sample;
    logic [1:0]  packet_kind;
    logic [7:0]  head_id;
    logic [13:0] depth_cm;
    logic        echo_missing;
    logic        auto_trigger_unsupported;
    logic        char_overrun;
    logic        range_mismatch;
    logic [31:0] frame_seq;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/sonar_return_frame_parser.sv @@
// Sonar return frame parser: byte-stream framing, echo sample output and frame summaries.
`default_nettype none

// The parser takes one received serial byte per input transfer and may take a
// new byte in every clock cycle while in_stall is low. Each byte is decoded
// in the cycle it is accepted: a small frame state machine hunts for the sync
// byte 'I', takes the type byte, requires the marker 'X', captures the nine
// header bytes, then passes echo samples (252 for type M, 500 for type G, none
// for P or unknown types) and finally skips bytes up to the 0xFC terminator,
// which yields one frame summary. A byte produces at most one result; each
// result is loaded into an output register, and a one-entry skid register
// behind it lets the parser accept one more byte while the output is stalled.
// in_stall rises only when the skid entry is occupied, so with an unstalled
// output the sustained rate is one byte per cycle. The range setting (reset
// value 5) is written through the cfg channel, which is always ready; it is
// sampled when the ninth header byte arrives, and writes are meant to happen
// only while the parser is idle.
module sonar_return_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_expected_range,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [7:0]       out_echo_sample,
  output logic [8:0]       out_sample_index,
  output logic             out_last_sample,
  output logic [1:0]       out_packet_kind,
  output logic [7:0]       out_head_id,
  output logic [13:0]      out_depth_cm,
  output logic             out_echo_missing,
  output logic             out_auto_trigger_unsupported,
  output logic             out_char_overrun,
  output logic             out_range_mismatch,
  output logic [31:0]      out_frame_seq
);
  import srfp_pkg::*;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  pkt_kind_t   ftype_r, ftype_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  hdr_r [HDR_LEN];
  logic [8:0]  smp_cnt_r, smp_cnt_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic        mismatch_r, mismatch_nxt;
  logic [7:0]  range_r;

  // Output register and skid entry.
  logic        out_valid_r;
  result_t     out_r;
  logic        skid_valid_r;
  result_t     skid_r;

  logic        accept;
  logic        has_res;
  result_t     res;
  logic        last_smp;
  logic        out_busy;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_busy  = out_valid_r && out_stall;

  // The last sample index depends on the frame type; only M and G frames
  // ever reach the sample phase.
  assign last_smp = (ftype_r == KIND_G) ? (smp_cnt_r == G_LAST_IDX)
                                        : (smp_cnt_r == M_LAST_IDX);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == SYNC_BYTE) phase_nxt = PH_TYPE;
        end
        PH_TYPE: phase_nxt = PH_MARK;
        PH_MARK: begin
          // A bad marker is dropped outright, not rechecked as a sync byte.
          phase_nxt = (in_rx_byte == MARK_BYTE) ? PH_HEADER : PH_HUNT;
        end
        PH_HEADER: begin
          if (hdr_cnt_r == HDR_LAST) begin
            phase_nxt = (ftype_r == KIND_M || ftype_r == KIND_G) ? PH_SAMPLES : PH_TERM;
          end
        end
        PH_SAMPLES: begin
          if (last_smp) phase_nxt = PH_TERM;
        end
        PH_TERM: begin
          if (in_rx_byte == TERM_BYTE) phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // Datapath and result formation.
  always_comb begin
    ftype_nxt    = ftype_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    smp_cnt_nxt  = smp_cnt_r;
    seq_nxt      = seq_r;
    mismatch_nxt = mismatch_r;
    has_res      = 1'b0;
    res          = '0;
    if (accept) begin
      unique case (phase_r)
        PH_TYPE: begin
          priority if (in_rx_byte == TYPE_M_BYTE) ftype_nxt = KIND_M;
          else if (in_rx_byte == TYPE_G_BYTE) ftype_nxt = KIND_G;
          else if (in_rx_byte == TYPE_P_BYTE) ftype_nxt = KIND_P;
          else ftype_nxt = KIND_UNKNOWN;
        end
        PH_MARK: begin
          hdr_cnt_nxt = '0;
        end
        PH_HEADER: begin
          if (hdr_cnt_r == HDR_LAST) begin
            hdr_cnt_nxt  = '0;
            smp_cnt_nxt  = '0;
            mismatch_nxt = (hdr_r[4] != range_r);
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          end
        end
        PH_SAMPLES: begin
          has_res          = 1'b1;
          res.result_kind  = RES_SAMPLE;
          res.echo_sample  = in_rx_byte;
          res.sample_index = smp_cnt_r;
          res.last_sample  = last_smp;
          smp_cnt_nxt      = last_smp ? 9'd0 : smp_cnt_r + 9'd1;
        end
        PH_TERM: begin
          if (in_rx_byte == TERM_BYTE) begin
            has_res                      = 1'b1;
            res.result_kind              = RES_SUMMARY;
            res.packet_kind              = ftype_r;
            res.head_id                  = hdr_r[0];
            // Depth is packed as two 7-bit bytes with the low bit of the
            // upper byte carrying depth bit 7.
            res.depth_cm                 = {hdr_r[6][6:1], hdr_r[6][0], hdr_r[5][6:0]};
            res.echo_missing             = !hdr_r[1][0];
            res.auto_trigger_unsupported = !hdr_r[1][2];
            res.char_overrun             = hdr_r[1][7];
            res.range_mismatch           = mismatch_r;
            res.frame_seq                = seq_r;
            seq_nxt                      = seq_r + 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      ftype_r     <= KIND_M;
      hdr_cnt_r   <= '0;
      smp_cnt_r   <= '0;
      seq_r       <= '0;
      mismatch_r  <= 1'b0;
      range_r     <= RANGE_RESET;
    end else begin
      phase_r    <= phase_nxt;
      ftype_r    <= ftype_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      smp_cnt_r  <= smp_cnt_nxt;
      seq_r      <= seq_nxt;
      mismatch_r <= mismatch_nxt;
      if (cfg_valid && cfg_ready) range_r <= cfg_expected_range;
    end
  end

  // Header capture; each byte lands at the current header position.
  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_HEADER) hdr_r[hdr_cnt_r] <= in_rx_byte;
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_busy) begin
      if (has_res) skid_valid_r <= 1'b1;
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_busy) begin
      if (has_res) skid_r <= res;
    end else if (skid_valid_r) begin
      out_r <= skid_r;
    end else if (has_res) begin
      out_r <= res;
    end
  end

  assign out_valid                    = out_valid_r;
  assign out_result_kind              = out_r.result_kind;
  assign out_echo_sample              = out_r.echo_sample;
  assign out_sample_index             = out_r.sample_index;
  assign out_last_sample              = out_r.last_sample;
  assign out_packet_kind              = out_r.packet_kind;
  assign out_head_id                  = out_r.head_id;
  assign out_depth_cm                 = out_r.depth_cm;
  assign out_echo_missing             = out_r.echo_missing;
  assign out_auto_trigger_unsupported = out_r.auto_trigger_unsupported;
  assign out_char_overrun             = out_r.char_overrun;
  assign out_range_mismatch           = out_r.range_mismatch;
  assign out_frame_seq                = out_r.frame_seq;

  // The skid entry is only ever filled behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry occupied while output register empty");

  // Only sample-bearing frame types may reach the sample phase.
  a_samples_type: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SAMPLES |-> (ftype_r == KIND_M || ftype_r == KIND_G))
    else $error("sample phase entered for a frame without samples");

  // The sample counter rests at zero outside the sample phase.
  a_smp_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_SAMPLES |-> smp_cnt_r == 9'd0)
    else $error("sample counter not cleared outside sample phase");

  // The header position never runs past the last header byte.
  a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r <= HDR_LAST)
    else $error("header counter out of range");

  // A summary transfer advances the sequence count by exactly one.
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_TERM && in_rx_byte == TERM_BYTE |=> seq_r == $past(seq_r) + 32'd1)
    else $error("sequence count did not advance on frame summary");

endmodule

`default_nettype wire
